// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the step pulse generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk and off while reset is held.
`define MSG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on the rising edge of clk and off while reset is held.
`define MSG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/msg_pkg.sv =====
// Types, constants and helpers shared by the step pulse generator modules.
package msg_pkg;

  localparam int NUM_MOTORS  = 3;
  localparam int MOTOR_SLOTS = 3;
  localparam int MOTOR_IDX_W = 2;
  localparam int REQ_W       = 3;
  localparam int AMOUNT_W    = 16;
  localparam int PATH_W      = 32;
  localparam int DELAY_W     = 16;
  localparam int RELOAD_W    = 12;
  localparam int SPR_W       = 16;
  localparam int DIVISOR_W   = 32;
  localparam int DIVIDEND_W  = 26;
  localparam int MIN_DELAY_SHIFT = 4;

  localparam logic [DELAY_W-1:0]    MIN_DELAY     = DELAY_W'(16);
  localparam logic [DELAY_W-1:0]    DELAY_MAX     = DELAY_W'(65535);
  localparam logic [DIVIDEND_W-1:0] US_PER_MINUTE = DIVIDEND_W'(60000000);
  localparam logic [SPR_W-1:0]      SPR_RESET     = SPR_W'(200);

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TICK       = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_DIR    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SET_DELAY  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SET_RPM    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESET_PATH = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_PATH  = 3'd5;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPR0    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPR1    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPR2    = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_DIR_INV = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]       req_type;
    logic [MOTOR_IDX_W-1:0] motor_index;
    logic                   backward;
    logic [AMOUNT_W-1:0]    amount;
  } msg_in_t;

  typedef struct packed {
    logic [MOTOR_SLOTS-1:0]   step_pins;
    logic [MOTOR_SLOTS-1:0]   dir_pins;
    logic signed [PATH_W-1:0] path_value;
    logic                     bad_motor;
  } msg_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } msg_div_stat_t;

  // Delay in microseconds to reload count: small nonzero delays are raised to the minimum.
  function automatic logic [RELOAD_W-1:0] reload_of(input logic [DELAY_W-1:0] delay);
    logic [DELAY_W-1:0] d;
    d = delay;
    if ((d != '0) && (d < MIN_DELAY)) begin
      d = MIN_DELAY;
    end
    return RELOAD_W'(d >> MIN_DELAY_SHIFT);
  endfunction

endpackage

// ===== rtl/msg_divider.sv =====
// Bit-serial restoring divider of the microseconds-per-minute constant by a 32-bit divisor.
module msg_divider
  import msg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVISOR_W-1:0]  divisor,
  output msg_div_stat_t         stat,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } div_state_t;

  div_state_t state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0]  div_r;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [DIVISOR_W:0]    rem_shift;
  logic [DIVISOR_W:0]    diff;
  logic                  ge;

  // One quotient bit per cycle: the dividend leaves dq_r at the top as the quotient enters below.
  assign rem_shift = {rem_r, dq_r[DIVIDEND_W-1]};
  assign ge        = rem_shift >= {1'b0, div_r};
  assign diff      = rem_shift - {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dq_nxt    = dq_r;
    case (state_r)
      DIV_RUN: begin
        rem_nxt = ge ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
        dq_nxt  = {dq_r[DIVIDEND_W-2:0], ge};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_IDLE, DIV_DONE: begin
      end
      default: begin
        state_nxt = DIV_IDLE;
      end
    endcase
    if (start) begin
      state_nxt = DIV_RUN;
      cnt_nxt   = CNT_W'(DIVIDEND_W - 1);
      rem_nxt   = '0;
      dq_nxt    = US_PER_MINUTE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DIV_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign stat.busy = (state_r == DIV_RUN);
  assign stat.done = (state_r == DIV_DONE);
  assign quotient  = dq_r;

endmodule

// ===== rtl/multi_stepper_step_generator_unit.sv =====
// Top level of the three-motor step pulse generator with its request and result channels.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+--------------------------------------------
//  in_      | input     | in_valid / in_stall   | msg_in_t: req_type, motor_index, ...
//  out_     | output    | out_valid / out_stall | msg_out_t: step_pins, dir_pins, ...
//  cfg_     | input     | cfg_we              | cfg_addr register index, cfg_wdata value
//
// A request other than set rpm passes through the command register and then the result register.
// For a set rpm request, the 26-bit quotient of 60000000 by the product of rpm
// and steps per revolution comes out of the serial divider one bit per cycle.
// One item is held in the command register while the previous result waits at the output.
// Reset is synchronous and active low; it clears all motor state and sets the configuration to its reset values.
// A stalled output holds its result; the held command then waits before updating state.
`include "assert_macros.svh"

module multi_stepper_step_generator_unit
  import msg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  msg_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output msg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers
  logic [SPR_W-1:0]       spr_r [MOTOR_SLOTS];
  logic [MOTOR_SLOTS-1:0] inv_r;

  // Per-motor state
  logic [PATH_W-1:0]   path_r     [NUM_MOTORS];
  logic [PATH_W-1:0]   path_nxt   [NUM_MOTORS];
  logic [RELOAD_W-1:0] cnt_r      [NUM_MOTORS];
  logic [RELOAD_W-1:0] cnt_nxt    [NUM_MOTORS];
  logic [RELOAD_W-1:0] reload_r   [NUM_MOTORS];
  logic [RELOAD_W-1:0] reload_nxt [NUM_MOTORS];
  logic [NUM_MOTORS-1:0] dir_back_r, dir_back_nxt;
  logic [NUM_MOTORS-1:0] level_r, level_nxt;

  // Command register, holding one accepted item until its result is written out
  logic    cmd_valid_r, cmd_valid_nxt;
  msg_in_t cmd_r;
  logic    prod_zero_r;

  // Result register
  logic     out_valid_r, out_valid_nxt;
  msg_out_t out_data_r;
  msg_out_t result;

  logic                  accept_in;
  logic                  cmd_done;
  logic                  cmd_motor_ok;
  logic                  cmd_is_rpm;
  logic                  in_motor_ok;
  logic                  div_start;
  logic [SPR_W-1:0]      spr_sel;
  logic [DIVISOR_W-1:0]  prod;
  msg_div_stat_t         div_stat;
  logic [DIVIDEND_W-1:0] quot;
  logic [DELAY_W-1:0]    rpm_delay;
  logic [RELOAD_W-1:0]   rpm_reload;
  logic [RELOAD_W-1:0]   delay_reload;

  // ---------------------------------------------------------------------------------------
  // Handshake. The command register takes a new item whenever it is empty or its present
  // item completes in this cycle, so an item can wait here while a result waits at the output.
  // ---------------------------------------------------------------------------------------
  assign in_motor_ok  = {1'b0, in_data.motor_index} < (MOTOR_IDX_W + 1)'(NUM_MOTORS);
  assign cmd_motor_ok = {1'b0, cmd_r.motor_index} < (MOTOR_IDX_W + 1)'(NUM_MOTORS);
  assign cmd_is_rpm   = (cmd_r.req_type == REQ_SET_RPM) && cmd_motor_ok;

  assign cmd_done  = cmd_valid_r && (!cmd_is_rpm || div_stat.done) &&
                     (!out_valid_r || !out_stall);
  assign in_stall  = cmd_valid_r && !cmd_done;
  assign accept_in = in_valid && !in_stall;

  assign cmd_valid_nxt = accept_in || (cmd_valid_r && !cmd_done);
  assign out_valid_nxt = cmd_done || (out_valid_r && out_stall);

  // ---------------------------------------------------------------------------------------
  // Set rpm: the product of rpm and steps per revolution is formed as the item is accepted
  // and registered in the divider, which then works through the quotient bit by bit.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    spr_sel = '0;
    for (int i = 0; i < MOTOR_SLOTS; i++) begin
      if (in_data.motor_index == MOTOR_IDX_W'(i)) begin
        spr_sel = spr_r[i];
      end
    end
  end

  assign prod      = DIVISOR_W'(in_data.amount) * DIVISOR_W'(spr_sel);
  assign div_start = accept_in && (in_data.req_type == REQ_SET_RPM) && in_motor_ok;

  msg_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (prod),
    .stat     (div_stat),
    .quotient (quot)
  );

  // A zero product stops the motor; a quotient above the 16-bit range saturates.
  always_comb begin
    if (prod_zero_r) begin
      rpm_delay = '0;
    end else if (quot[DIVIDEND_W-1:DELAY_W] != '0) begin
      rpm_delay = DELAY_MAX;
    end else begin
      rpm_delay = quot[DELAY_W-1:0];
    end
  end

  assign rpm_reload   = reload_of(rpm_delay);
  assign delay_reload = reload_of(cmd_r.amount);

  // ---------------------------------------------------------------------------------------
  // Motor state update, applied in the cycle the held item completes.
  // ---------------------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < NUM_MOTORS; i++) begin
      path_nxt[i]     = path_r[i];
      cnt_nxt[i]      = cnt_r[i];
      reload_nxt[i]   = reload_r[i];
      dir_back_nxt[i] = dir_back_r[i];
      level_nxt[i]    = level_r[i];
      if (cmd_done) begin
        case (cmd_r.req_type)
          REQ_TICK: begin
            if (cnt_r[i] != '0) begin
              cnt_nxt[i] = cnt_r[i] - RELOAD_W'(1);
            end else begin
              if (reload_r[i] != '0) begin
                level_nxt[i] = ~level_r[i];
                path_nxt[i]  = dir_back_r[i] ? (path_r[i] - PATH_W'(1))
                                             : (path_r[i] + PATH_W'(1));
              end
              cnt_nxt[i] = reload_r[i];
            end
          end
          REQ_SET_DIR: begin
            if (cmd_r.motor_index == MOTOR_IDX_W'(i)) begin
              dir_back_nxt[i] = cmd_r.backward;
            end
          end
          REQ_SET_DELAY: begin
            if (cmd_r.motor_index == MOTOR_IDX_W'(i)) begin
              reload_nxt[i] = delay_reload;
            end
          end
          REQ_SET_RPM: begin
            if (cmd_r.motor_index == MOTOR_IDX_W'(i)) begin
              reload_nxt[i] = rpm_reload;
            end
          end
          REQ_RESET_PATH: begin
            if (cmd_r.motor_index == MOTOR_IDX_W'(i)) begin
              path_nxt[i] = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result: pin levels after the update, the path only for a valid read request.
  always_comb begin
    result = '0;
    for (int i = 0; i < NUM_MOTORS; i++) begin
      result.step_pins[i] = level_nxt[i];
      result.dir_pins[i]  = ~dir_back_nxt[i] ^ inv_r[i];
      if ((cmd_r.req_type == REQ_READ_PATH) && (cmd_r.motor_index == MOTOR_IDX_W'(i))) begin
        result.path_value = path_r[i];
      end
    end
    result.bad_motor = (cmd_r.req_type inside {[REQ_SET_DIR:REQ_READ_PATH]}) && !cmd_motor_ok;
  end

  // ---------------------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      dir_back_r  <= '0;
      level_r     <= '0;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        path_r[i]   <= '0;
        cnt_r[i]    <= '0;
        reload_r[i] <= '0;
      end
    end else begin
      cmd_valid_r <= cmd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      dir_back_r  <= dir_back_nxt;
      level_r     <= level_nxt;
      for (int i = 0; i < NUM_MOTORS; i++) begin
        path_r[i]   <= path_nxt[i];
        cnt_r[i]    <= cnt_nxt[i];
        reload_r[i] <= reload_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      cmd_r       <= in_data;
      prod_zero_r <= (in_data.amount == '0) || (spr_sel == '0);
    end
    if (cmd_done) begin
      out_data_r <= result;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOTOR_SLOTS; i++) begin
        spr_r[i] <= SPR_RESET;
      end
      inv_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_SPR0:    spr_r[0] <= cfg_wdata[SPR_W-1:0];
        CFG_SPR1:    spr_r[1] <= cfg_wdata[SPR_W-1:0];
        CFG_SPR2:    spr_r[2] <= cfg_wdata[SPR_W-1:0];
        CFG_DIR_INV: inv_r    <= cfg_wdata[MOTOR_SLOTS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------
  // The divider only runs on behalf of a held set rpm item.
  `MSG_ASSERT_IMPL(a_div_owner, div_stat.busy, cmd_valid_r && (cmd_r.req_type == REQ_SET_RPM), "divider runs without a set rpm item")
  // A set rpm item never completes before its quotient is ready.
  `MSG_ASSERT_IMPL(a_rpm_wait, cmd_done && cmd_is_rpm, div_stat.done, "set rpm item completed before the divider finished")
  // A flagged motor index never carries a path value.
  `MSG_ASSERT_IMPL(a_bad_no_path, out_valid_r && out_data_r.bad_motor, out_data_r.path_value == '0, "bad motor result carries a path value")
  // Starting a division leaves the divider busy in the next cycle.
  `MSG_ASSERT_NEXT(a_div_starts, div_start, div_stat.busy && !div_stat.done, "divider did not start")

endmodule

// ===== verif/step_pulse_checker.sv =====
// Checker for the step pulse generator: predicts every result and compares it with the block.
module step_pulse_checker
  import msg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  msg_in_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  msg_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PATH_W-1:0]   path_cnt  [NUM_MOTORS];
  logic                go_back   [NUM_MOTORS];
  logic [RELOAD_W-1:0] count_left[NUM_MOTORS];
  logic [RELOAD_W-1:0] reload    [NUM_MOTORS];
  logic                step_lvl  [NUM_MOTORS];
  logic [SPR_W-1:0]    spr       [NUM_MOTORS];
  logic [2:0]          invert_mask;
  msg_out_t            pin_reports_q[$];

  // Delays below the minimum are raised to it; zero keeps the motor stopped.
  function automatic logic [RELOAD_W-1:0] delay_to_reload(input int unsigned delay_us);
    int unsigned d;
    d = delay_us;
    if (d != 0 && d < int'(MIN_DELAY)) begin
      d = int'(MIN_DELAY);
    end
    return RELOAD_W'(d / int'(MIN_DELAY));
  endfunction

  // Applies one request to the motor state and returns the pin and path report it causes.
  function automatic msg_out_t apply_request(input msg_in_t rq);
    msg_out_t    res;
    int          m;
    int          i;
    logic [63:0] prod;
    logic [63:0] delay;
    res = '0;
    m = int'(rq.motor_index);
    if (rq.req_type == REQ_TICK) begin
      for (i = 0; i < NUM_MOTORS; i++) begin
        if (count_left[i] != '0) begin
          count_left[i] = count_left[i] - 1'b1;
        end else begin
          if (reload[i] != '0) begin
            step_lvl[i] = ~step_lvl[i];
            path_cnt[i] = go_back[i] ? path_cnt[i] - 1 : path_cnt[i] + 1;
          end
          count_left[i] = reload[i];
        end
      end
    end else if (rq.req_type <= REQ_READ_PATH) begin
      if (m >= NUM_MOTORS) begin
        res.bad_motor = 1'b1;
      end else begin
        case (rq.req_type)
          REQ_SET_DIR: begin
            go_back[m] = rq.backward;
          end
          REQ_SET_DELAY: begin
            reload[m] = delay_to_reload(rq.amount);
          end
          REQ_SET_RPM: begin
            prod  = 64'(rq.amount) * 64'(spr[m]);
            delay = '0;
            if (prod != '0) begin
              delay = 64'(US_PER_MINUTE) / prod;
              if (delay > 64'(DELAY_MAX)) begin
                delay = 64'(DELAY_MAX);
              end
            end
            reload[m] = delay_to_reload(32'(delay));
          end
          REQ_RESET_PATH: begin
            path_cnt[m] = '0;
          end
          REQ_READ_PATH: begin
            res.path_value = path_cnt[m];
          end
          default: begin
          end
        endcase
      end
    end
    for (i = 0; i < NUM_MOTORS; i++) begin
      res.dir_pins[i]  = ~go_back[i] ^ invert_mask[i];
      res.step_pins[i] = step_lvl[i];
    end
    return res;
  endfunction

  always @(posedge clk) begin : watch
    msg_out_t want;
    int       i;
    if (!rst_n) begin
      for (i = 0; i < NUM_MOTORS; i++) begin
        path_cnt[i]   = '0;
        go_back[i]    = 1'b0;
        count_left[i] = '0;
        reload[i]     = '0;
        step_lvl[i]   = 1'b0;
        spr[i]        = SPR_RESET;
      end
      invert_mask = '0;
      pin_reports_q.delete();
    end else begin
      // Results are compared before this edge's item is predicted: no result can belong to it.
      if (out_valid && !out_stall) begin
        if (pin_reports_q.size() == 0) begin
          $display("%0t: result arrived with nothing expected: actual %p", $time, out_data);
          fail_count++;
        end else begin
          want = pin_reports_q.pop_front();
          if (out_data.step_pins !== want.step_pins) begin
            $display("%0t: step_pins expected %b actual %b", $time,
                     want.step_pins, out_data.step_pins);
            fail_count++;
          end
          if (out_data.dir_pins !== want.dir_pins) begin
            $display("%0t: dir_pins expected %b actual %b", $time,
                     want.dir_pins, out_data.dir_pins);
            fail_count++;
          end
          if (out_data.path_value !== want.path_value) begin
            $display("%0t: path_value expected %0d actual %0d", $time,
                     want.path_value, out_data.path_value);
            fail_count++;
          end
          if (out_data.bad_motor !== want.bad_motor) begin
            $display("%0t: bad_motor expected %b actual %b", $time,
                     want.bad_motor, out_data.bad_motor);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_SPR0:    spr[0] = cfg_wdata;
          CFG_SPR1:    spr[1] = cfg_wdata;
          CFG_SPR2:    spr[2] = cfg_wdata;
          CFG_DIR_INV: invert_mask = cfg_wdata[2:0];
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        pin_reports_q.push_back(apply_request(in_data));
      end
    end
    pending <= pin_reports_q.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top: drives requests and configuration into the step pulse generator and gives the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msg_pkg::*;

  // Request codes the block does not use; they must leave all state untouched.
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  // The first motor index that names no motor.
  localparam logic [MOTOR_IDX_W-1:0] NO_MOTOR = MOTOR_IDX_W'(NUM_MOTORS);
  localparam int PHASES           = 5;
  localparam int ITEMS_PER_PHASE  = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  msg_in_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  msg_out_t              out_data;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    pending;
  int                    fail_count;

  // Sender pacing: items left in the current burst.
  int                    burst_left;
  // Steps per revolution currently programmed, used to steer rpm amounts.
  int unsigned           spr_now[NUM_MOTORS];

  always #1ns clk = ~clk;

  multi_stepper_step_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  step_pulse_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  function automatic msg_in_t request(input logic [REQ_W-1:0] req,
                                      input logic [MOTOR_IDX_W-1:0] m,
                                      input logic back, input logic [AMOUNT_W-1:0] amt);
    msg_in_t rq;
    rq.req_type    = req;
    rq.motor_index = m;
    rq.backward    = back;
    rq.amount      = amt;
    return rq;
  endfunction

  // Random request mix. Ticks dominate so that the motors actually step, and most delays are
  // kept short: a long reload leaves a motor counting down for thousands of ticks, during
  // which nothing interesting happens to it. The occasional full-range amount still reaches
  // every bit of the field.
  function automatic msg_in_t random_request();
    msg_in_t     rq;
    int          pick;
    int unsigned lo;
    rq.motor_index = ($urandom_range(0, 9) == 0) ? NO_MOTOR
                                                 : MOTOR_IDX_W'($urandom_range(0, NUM_MOTORS - 1));
    rq.backward    = 1'($urandom_range(0, 1));
    rq.amount      = AMOUNT_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 38) begin
      rq.req_type = REQ_TICK;
    end else if (pick < 50) begin
      rq.req_type = REQ_SET_DIR;
    end else if (pick < 66) begin
      rq.req_type = REQ_SET_DELAY;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        rq.amount = AMOUNT_W'($urandom_range(0, 64));
      end else if (pick < 90) begin
        rq.amount = AMOUNT_W'($urandom_range(0, 1024));
      end else if (pick < 99) begin
        rq.amount = AMOUNT_W'($urandom_range(0, 4095));
      end
    end else if (pick < 78) begin
      rq.req_type = REQ_SET_RPM;
      // Aim for a product of rpm and steps per revolution large enough for a short delay.
      if (rq.motor_index != NO_MOTOR && $urandom_range(0, 19) != 0) begin
        lo = 58600 / spr_now[rq.motor_index] + 1;
        if (lo > 65535) begin
          lo = 65535;
        end
        rq.amount = AMOUNT_W'($urandom_range(lo, 65535));
      end
    end else if (pick < 90) begin
      rq.req_type = REQ_READ_PATH;
    end else if (pick < 95) begin
      rq.req_type = REQ_RESET_PATH;
    end else begin
      rq.req_type = REQ_W'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
    end
    return rq;
  endfunction

  // Bursts of random length separated by random gaps; the odd long burst gives stretches
  // without idling.
  task automatic pace();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
  endtask

  // Offers one item and returns at the edge at which the block takes it.
  task automatic send_request(input msg_in_t rq);
    in_data  <= rq;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every expected result has come back, then idles before returning.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
  endtask

  // Writes all four registers, one per cycle, while the block is idle.
  task automatic write_config(input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                              input logic [CFG_DATA_W-1:0] s2,
                              input logic [CFG_DATA_W-1:0] mask);
    logic [CFG_ADDR_W-1:0] idx[4];
    logic [CFG_DATA_W-1:0] val[4];
    idx = '{CFG_SPR0, CFG_SPR1, CFG_SPR2, CFG_DIR_INV};
    val = '{s0, s1, s2, mask};
    spr_now[0] = s0;
    spr_now[1] = s1;
    spr_now[2] = s2;
    foreach (idx[k]) begin
      cfg_we    <= 1'b1;
      cfg_addr  <= idx[k];
      cfg_wdata <= val[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Receiver: stalls in modes of random length, from never to three times in four. After the
  // first three hundred results, and every nine hundred after that, it holds off for a long stretch,
  // so that the block's output and command register fill up and it has to stall its input.
  initial begin : receiver
    int taken;
    int next_hold;
    int hold_left;
    int mode;
    int mode_left;
    taken     = 0;
    next_hold = 300;
    hold_left = 0;
    mode      = 0;
    mode_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        taken++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (taken >= next_hold) begin
        next_hold += 900;
        hold_left = 400;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 7) == 0);
          default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Sender and configuration sequence.
  initial begin : stimulus
    msg_in_t directed[$];
    int      phase;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_addr  <= '0;
    cfg_wdata <= '0;
    burst_left = 0;
    foreach (spr_now[k]) begin
      spr_now[k] = SPR_RESET;
    end

    // Directed items under the reset configuration. Motor 2 is given the longest delay and
    // then stopped again before any tick, so that it never sits in a long countdown.
    directed.push_back(request(REQ_READ_PATH,  2'd0, 1'b0, 16'h0000));
    directed.push_back(request(REQ_TICK,       NO_MOTOR, 1'b1, 16'hFFFF));
    directed.push_back(request(REQ_SET_DELAY,  2'd0, 1'b0, 16'd1));
    directed.push_back(request(REQ_SET_DELAY,  2'd1, 1'b0, 16'd17));
    directed.push_back(request(REQ_SET_DELAY,  2'd2, 1'b0, 16'hFFFF));
    directed.push_back(request(REQ_SET_RPM,    2'd2, 1'b0, 16'd0));
    directed.push_back(request(REQ_SET_DIR,    2'd1, 1'b1, 16'h0000));
    directed.push_back(request(REQ_TICK,       2'd0, 1'b0, 16'h0000));
    directed.push_back(request(REQ_TICK,       2'd1, 1'b0, 16'h0000));
    directed.push_back(request(REQ_TICK,       2'd2, 1'b0, 16'h0000));
    directed.push_back(request(REQ_READ_PATH,  2'd1, 1'b0, 16'h0000));
    // Slowest speed saturates the delay; fastest drops below the minimum delay.
    directed.push_back(request(REQ_SET_RPM,    2'd0, 1'b0, 16'd1));
    directed.push_back(request(REQ_SET_RPM,    2'd1, 1'b0, 16'hFFFF));
    directed.push_back(request(REQ_SET_DELAY,  2'd0, 1'b0, 16'd15));
    directed.push_back(request(REQ_SET_DELAY,  2'd2, 1'b0, 16'd0));
    directed.push_back(request(REQ_TICK,       2'd0, 1'b1, 16'h1234));
    directed.push_back(request(REQ_RESET_PATH, 2'd1, 1'b0, 16'h0000));
    directed.push_back(request(REQ_READ_PATH,  2'd1, 1'b0, 16'h0000));
    // Every motor request with an index beyond the last motor is flagged and ignored.
    directed.push_back(request(REQ_SET_DIR,    NO_MOTOR, 1'b1, 16'h0000));
    directed.push_back(request(REQ_SET_DELAY,  NO_MOTOR, 1'b0, 16'd16));
    directed.push_back(request(REQ_SET_RPM,    NO_MOTOR, 1'b0, 16'd100));
    directed.push_back(request(REQ_RESET_PATH, NO_MOTOR, 1'b0, 16'h0000));
    directed.push_back(request(REQ_READ_PATH,  NO_MOTOR, 1'b0, 16'h0000));
    // Unused codes change nothing and are never flagged.
    directed.push_back(request(REQ_UNUSED_LO,  2'd1, 1'b1, 16'h5555));
    directed.push_back(request(REQ_UNUSED_HI,  NO_MOTOR, 1'b1, 16'hFFFF));

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[k]) begin
      pace();
      send_request(directed[k]);
    end
    settle();

    // Each phase reprograms every register, including the extremes of the speed conversion
    // (one step per revolution, and the largest value, where most products overflow the
    // dividend and stop the motor) and both ends of the inversion mask.
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_config(16'd1, 16'd1, 16'd1, 16'h0007);
        1: write_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        2: write_config(16'd1, 16'hFFFF, SPR_RESET, 16'h0005);
        default: write_config(CFG_DATA_W'($urandom_range(1, 65535)),
                              CFG_DATA_W'($urandom_range(1, 65535)),
                              CFG_DATA_W'($urandom_range(1, 65535)),
                              CFG_DATA_W'($urandom));
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pace();
        send_request(random_request());
      end
      settle();
    end

    // Wait on for anything left over, then give the verdict.
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin : watchdog
    #2ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/msg_pkg.sv
rtl/msg_divider.sv
rtl/multi_stepper_step_generator_unit.sv
verif/step_pulse_checker.sv
verif/tb.sv
